/* src/mesh_frame_deframer_unit_assert.svh */
// Assertion macros shared by the deframer RTL.
`ifndef MESH_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define MESH_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

/* src/mfd_pkg.sv */
// Shared types and constants of the mesh frame deframer.
package mfd_pkg;

	// Configuration port geometry: four 32-bit registers at 4-byte spacing
	localparam int unsigned CfgAddrW = 4;
	localparam int unsigned CfgDataW = 32;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_HEADER_FIRST  = 2'd0;
	localparam reg_idx_t REG_HEADER_SECOND = 2'd1;
	localparam reg_idx_t REG_MAX_FRAME_LEN = 2'd2;
	localparam reg_idx_t REG_CONN_TYPE     = 2'd3;

	// Reset values of the registers
	localparam logic [7:0] HEADER_FIRST_RST  = 8'hF1;
	localparam logic [7:0] HEADER_SECOND_RST = 8'hDD;
	localparam logic [6:0] MAX_FRAME_LEN_RST = 7'd127;
	localparam logic [7:0] CONN_TYPE_RST     = 8'h01;

	// Frame constants
	localparam logic [7:0] MIN_FRAME_LEN  = 8'd5;
	localparam logic [7:0] ADDR_BYTES     = 8'd4;
	localparam logic [7:0] SENDER_MARK    = 8'd2;

	// Live register values seen by the datapath
	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [6:0] max_frame_length;
		logic [7:0] conn_type_code;
	} cfg_t;

	// Frame phase, one-hot
	typedef enum logic [7:0] {
		PH_HUNT1   = 8'b0000_0001,
		PH_HUNT2   = 8'b0000_0010,
		PH_LENGTH  = 8'b0000_0100,
		PH_SEND0   = 8'b0000_1000,
		PH_SEND1   = 8'b0001_0000,
		PH_DEST0   = 8'b0010_0000,
		PH_DEST1   = 8'b0100_0000,
		PH_PAYLOAD = 8'b1000_0000
	} phase_t;

endpackage

/* src/mfd_cfg_regs.sv */
// APB-style configuration register file of the deframer.
module mfd_cfg_regs
	import mfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output cfg_t                cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = paddr[CfgAddrW-1:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	// Register writes on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first     <= HEADER_FIRST_RST;
			cfg_q.header_second    <= HEADER_SECOND_RST;
			cfg_q.max_frame_length <= MAX_FRAME_LEN_RST;
			cfg_q.conn_type_code   <= CONN_TYPE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_HEADER_FIRST:  cfg_q.header_first     <= pwdata[7:0];
				REG_HEADER_SECOND: cfg_q.header_second    <= pwdata[7:0];
				REG_MAX_FRAME_LEN: cfg_q.max_frame_length <= pwdata[6:0];
				REG_CONN_TYPE:     cfg_q.conn_type_code   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_HEADER_FIRST:  prdata = {24'd0, cfg_q.header_first};
			REG_HEADER_SECOND: prdata = {24'd0, cfg_q.header_second};
			REG_MAX_FRAME_LEN: prdata = {25'd0, cfg_q.max_frame_length};
			REG_CONN_TYPE:     prdata = {24'd0, cfg_q.conn_type_code};
			default:           prdata = '0;
		endcase
	end

endmodule

/* src/mesh_frame_deframer_unit.sv */
// Top level of the header-hunting, length-prefixed mesh frame deframer.
//
//  channel | signals                                   | direction | beat
//  --------+-------------------------------------------+-----------+--------------------
//  in      | in_valid, in_ready, in_byte               | sink      | one received byte
//  out     | out_valid, out_ready, out_byte, out_last  | source    | one reframed byte
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | slave     | one register access
//          | prdata, pready                            |           |
//
// One input beat per cycle while in_ready is high; a result, when the byte makes
// one, is registered in the output register in the cycle after the input beat.
// The single output register sets the pace: in_ready is high while it is
// empty or being drained, so a stalled out channel stops input once it holds a beat.
// Reset (arst_n low) clears the phase to hunting and restores register defaults.
module mesh_frame_deframer_unit
	import mfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready
);

`include "mesh_frame_deframer_unit_assert.svh"

	cfg_t       cfg;
	phase_t     phase_q, phase_d;
	logic [6:0] left_q, left_d;
	logic [6:0] plen_q, plen_d;
	logic [15:0] sender_q, sender_d;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       in_fire;
	logic       emit;
	logic [7:0] ob;
	logic       lst;
	phase_t     hunt_ph;
	logic       len_bad;

	mfd_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready    = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// Restart of the hunt: this byte may itself be a first header byte
	assign hunt_ph = (in_byte == cfg.header_first) ? PH_HUNT2 : PH_HUNT1;
	assign len_bad = (in_byte < MIN_FRAME_LEN) || (in_byte > {1'b0, cfg.max_frame_length});

	// Phase logic and result byte selection
	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		plen_d   = plen_q;
		sender_d = sender_q;
		emit     = 1'b0;
		ob       = '0;
		lst      = 1'b0;
		case (phase_q)
			PH_HUNT1: begin
				phase_d = hunt_ph;
			end
			PH_HUNT2: begin
				phase_d = (in_byte == cfg.header_second) ? PH_LENGTH : hunt_ph;
			end
			PH_LENGTH: begin
				if (len_bad) begin
					phase_d = hunt_ph;
				end else begin
					plen_d  = 7'(in_byte - ADDR_BYTES);
					left_d  = 7'(in_byte - ADDR_BYTES);
					emit    = 1'b1;
					ob      = cfg.conn_type_code;
					phase_d = PH_SEND0;
				end
			end
			PH_SEND0: begin
				sender_d[15:8] = in_byte;
				emit    = 1'b1;
				ob      = SENDER_MARK;
				phase_d = PH_SEND1;
			end
			PH_SEND1: begin
				sender_d[7:0] = in_byte;
				emit    = 1'b1;
				ob      = {1'b0, plen_q};
				phase_d = PH_DEST0;
			end
			PH_DEST0: begin
				emit    = 1'b1;
				ob      = sender_q[15:8];
				phase_d = PH_DEST1;
			end
			PH_DEST1: begin
				emit    = 1'b1;
				ob      = sender_q[7:0];
				phase_d = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				emit = 1'b1;
				ob   = in_byte;
				if (left_q <= 7'd1) begin
					left_d  = '0;
					lst     = 1'b1;
					phase_d = PH_HUNT1;
				end else begin
					left_d = left_q - 7'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
	end

	// Frame state, advanced on each input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT1;
			left_q   <= '0;
			plen_q   <= '0;
			sender_q <= '0;
		end else if (in_fire) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			plen_q   <= plen_d;
			sender_q <= sender_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			out_byte_q <= ob;
			out_last_q <= lst;
		end
	end

	`MFD_ASSERT_NXT(a_payload_echo, in_fire && (phase_q == PH_PAYLOAD),
		out_valid_q && (out_byte_q == $past(in_byte)))
	`MFD_ASSERT_IMP(a_payload_left_nonzero, phase_q == PH_PAYLOAD, left_q != 7'd0)
	`MFD_ASSERT_NXT(a_last_rehunts, in_fire && emit && lst, phase_q == PH_HUNT1)
	`MFD_ASSERT_NXT(a_hunt_silent, in_fire && (phase_q == PH_HUNT1) && !out_valid_q,
		!out_valid_q)
	`MFD_ASSERT_IMP(a_ready_when_empty, !out_valid_q, in_ready)

endmodule

/* verif/tb_mesh_frame_deframer_unit.sv */
// Self-checking testbench for the mesh frame deframer: predicts reframed beats and checks them.
`timescale 1ns / 1ps

module tb_mesh_frame_deframer_unit
	import mfd_pkg::*;
;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_HOLD  = 4;

	// One beat of the reframed output stream
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          in_byte = 8'h00;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          out_byte;
	logic                out_last;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CfgAddrW-1:0] paddr = '0;
	logic [CfgDataW-1:0] pwdata = '0;
	logic [CfgDataW-1:0] prdata;
	logic                pready;

	// Deframer shadow state and live register copy
	cfg_t        live_cfg = '{header_first: HEADER_FIRST_RST, header_second: HEADER_SECOND_RST,
		max_frame_length: MAX_FRAME_LEN_RST, conn_type_code: CONN_TYPE_RST};
	phase_t      frame_phase = PH_HUNT1;
	logic [6:0]  bytes_left = '0;
	logic [6:0]  body_len = '0;
	logic [15:0] src_addr = '0;

	frame_beat_t reframed_q[$];
	frame_beat_t head_beat;
	int          err_count = 0;
	int unsigned cycle_count = 0;
	bit          idle_en = 1'b0;
	int          stall_left = 0;

	mesh_frame_deframer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Back-pressure on the out channel, random stall bursts while idling is on
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 10);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each out beat with the oldest predicted beat
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (reframed_q.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual out_byte=%02h out_last=%0b",
					$time, out_byte, out_last);
				err_count++;
			end else begin
				head_beat = reframed_q.pop_front();
				if (out_byte !== head_beat.data) begin
					$display("%0t: out_byte mismatch: expected %02h, actual %02h",
						$time, head_beat.data, out_byte);
					err_count++;
				end
				if (out_last !== head_beat.last) begin
					$display("%0t: out_last mismatch: expected %0b, actual %0b",
						$time, head_beat.last, out_last);
					err_count++;
				end
			end
		end
	end

	// A rejected byte is rechecked as a possible first header byte
	function automatic phase_t restart_hunt(input logic [7:0] b);
		return (b == live_cfg.header_first) ? PH_HUNT2 : PH_HUNT1;
	endfunction

	// Advance the shadow deframer by one received byte, queue the beat it makes
	function automatic void deframe_byte(input logic [7:0] b);
		frame_beat_t beat;
		beat.data = 8'h00;
		beat.last = 1'b0;
		case (frame_phase)
			PH_HUNT1: begin
				frame_phase = restart_hunt(b);
				return;
			end
			PH_HUNT2: begin
				frame_phase = (b == live_cfg.header_second) ? PH_LENGTH : restart_hunt(b);
				return;
			end
			PH_LENGTH: begin
				if (b < MIN_FRAME_LEN || b > {1'b0, live_cfg.max_frame_length}) begin
					frame_phase = restart_hunt(b);
					return;
				end
				body_len = 7'(b - ADDR_BYTES);
				bytes_left = body_len;
				beat.data = live_cfg.conn_type_code;
				frame_phase = PH_SEND0;
			end
			PH_SEND0: begin
				src_addr[15:8] = b;
				beat.data = SENDER_MARK;
				frame_phase = PH_SEND1;
			end
			PH_SEND1: begin
				src_addr[7:0] = b;
				beat.data = {1'b0, body_len};
				frame_phase = PH_DEST0;
			end
			PH_DEST0: begin
				beat.data = src_addr[15:8];
				frame_phase = PH_DEST1;
			end
			PH_DEST1: begin
				beat.data = src_addr[7:0];
				frame_phase = PH_PAYLOAD;
			end
			default: begin
				beat.data = b;
				if (bytes_left <= 7'd1) begin
					bytes_left = '0;
					beat.last = 1'b1;
					frame_phase = PH_HUNT1;
				end else begin
					bytes_left = bytes_left - 7'd1;
				end
			end
		endcase
		reframed_q.push_back(beat);
	endfunction

	function automatic void apply_reg(input reg_idx_t idx, input logic [7:0] value);
		case (idx)
			REG_HEADER_FIRST:  live_cfg.header_first = value;
			REG_HEADER_SECOND: live_cfg.header_second = value;
			REG_MAX_FRAME_LEN: live_cfg.max_frame_length = value[6:0];
			REG_CONN_TYPE:     live_cfg.conn_type_code = value;
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] reg_value(input reg_idx_t idx);
		case (idx)
			REG_HEADER_FIRST:  return {24'h0, live_cfg.header_first};
			REG_HEADER_SECOND: return {24'h0, live_cfg.header_second};
			REG_MAX_FRAME_LEN: return {25'h0, live_cfg.max_frame_length};
			default:           return {24'h0, live_cfg.conn_type_code};
		endcase
	endfunction

	// Send one byte; random gap first when idling is on
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		deframe_byte(b);
	endtask

	task automatic end_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (reframed_q.size() != 0) @(posedge clk);
		repeat (DRAIN_HOLD) @(posedge clk);
	endtask

	// Register write: setup cycle then access cycle, junk in the unused upper bits
	task automatic cfg_write(input reg_idx_t idx, input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {($urandom_range(0, 1) != 0) ? 24'($urandom()) : 24'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		apply_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic cfg_read_check(input reg_idx_t idx);
		logic [31:0] mask;
		mask = (idx == REG_MAX_FRAME_LEN) ? 32'h7F : 32'hFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if ((prdata & mask) !== reg_value(idx)) begin
			$display("%0t: register %0d readback mismatch: expected %08h, actual %08h",
				$time, idx, reg_value(idx), prdata & mask);
			err_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] hf, input logic [7:0] hs,
		input logic [7:0] max_len, input logic [7:0] conn);
		cfg_write(REG_HEADER_FIRST, hf);
		cfg_write(REG_HEADER_SECOND, hs);
		cfg_write(REG_MAX_FRAME_LEN, max_len);
		cfg_write(REG_CONN_TYPE, conn);
	endtask

	// Header, length, then the body if the length passes; returns bytes sent
	task automatic send_frame(input logic [7:0] len, output int n_sent);
		send_byte(live_cfg.header_first);
		send_byte(live_cfg.header_second);
		send_byte(len);
		n_sent = 3;
		if (len >= MIN_FRAME_LEN && len <= {1'b0, live_cfg.max_frame_length}) begin
			repeat (len) send_byte(8'($urandom()));
			n_sent += len;
		end
	endtask

	// Mostly well-formed frames with random content, plus noise, broken headers and bad lengths
	task automatic random_frames(input int n_bytes);
		int sent;
		int kind;
		int hi;
		int len;
		int n;
		sent = 0;
		while (sent < n_bytes) begin
			kind = $urandom_range(0, 9);
			hi = live_cfg.max_frame_length;
			if (kind == 0) begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom()));
			end else if (kind == 1) begin
				send_byte(live_cfg.header_first);
				send_byte(8'($urandom()));
			end else begin
				if (kind == 2)
					len = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4) : $urandom_range(hi + 1, 255);
				else if (hi < MIN_FRAME_LEN)
					len = $urandom_range(0, 255);
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(MIN_FRAME_LEN, hi);
				else
					len = $urandom_range(MIN_FRAME_LEN, (hi < 24) ? hi : 24);
				send_frame(8'(len), n);
				sent += n;
			end
		end
		end_input();
		wait_drain();
	endtask

	task automatic test_directed_frames();
		logic [7:0] script [21];
		// noise, repeated first header, short length, second-header miss,
		// long lengths (one of them a first header byte), then a minimal frame
		script = '{8'h00, 8'hFF, HEADER_FIRST_RST, HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h04,
			HEADER_FIRST_RST, 8'h37, HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h80,
			HEADER_FIRST_RST, HEADER_SECOND_RST, HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h05,
			8'hAB, 8'hCD, 8'h12, 8'h34, 8'h00};
		idle_en = 1'b1;
		foreach (script[k]) send_byte(script[k]);
		end_input();
		wait_drain();
	endtask

	task automatic test_register_access();
		for (int r = 0; r < 4; r++) cfg_read_check(reg_idx_t'(r));
		set_config(8'hA5, 8'h5A, 8'hC3, 8'h7E);
		for (int r = 0; r < 4; r++) cfg_read_check(reg_idx_t'(r));
	endtask

	// Register extremes: equal headers, shortest and unusable limits, edge codes
	task automatic test_config_extremes();
		set_config(8'h00, 8'h00, 8'd5, 8'hFF);
		random_frames(60);
		set_config(8'hFF, 8'hFF, 8'd4, 8'h00);
		random_frames(60);
		set_config(8'hFF, 8'h00, 8'd0, 8'h80);
		random_frames(60);
		set_config(8'h00, 8'hFF, 8'd127, 8'h01);
		random_frames(60);
	endtask

	task automatic test_random_frames();
		int sel;
		logic [7:0] hf;
		logic [7:0] hs;
		logic [6:0] max_len;
		for (int p = 0; p < 7; p++) begin
			hf = 8'($urandom());
			hs = ($urandom_range(0, 5) == 0) ? hf : 8'($urandom());
			sel = $urandom_range(0, 9);
			if (sel == 0)
				max_len = 7'd5;
			else if (sel == 1)
				max_len = 7'd127;
			else if (sel == 2)
				max_len = 7'($urandom_range(0, 4));
			else
				max_len = 7'($urandom_range(5, 127));
			set_config(hf, hs, {1'($urandom()), max_len}, 8'($urandom()));
			idle_en = ($urandom_range(0, 3) != 0);
			random_frames(230);
		end
	endtask

	task automatic test_quiet_tail();
		idle_en = 1'b0;
		set_config(HEADER_FIRST_RST, HEADER_SECOND_RST, {1'b0, MAX_FRAME_LEN_RST}, 8'($urandom()));
		random_frames(100);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_frames();
		test_register_access();
		test_config_extremes();
		test_random_frames();
		test_quiet_tail();
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
